### hdl/lba_pkg.sv
// Shared types and constants for the linked block allocator.
// No dependencies; imported by linked_block_allocator_top.
package lba_pkg;

  localparam int SECTOR_COUNT = 1024;
  localparam int FILE_SLOTS   = 128;
  localparam int MAX_RUN      = 32;

  localparam int SEC_AW  = $clog2(SECTOR_COUNT);
  localparam int LINK_W  = SEC_AW + 1;
  localparam int TAB_AW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int TOT_W   = $clog2(FILE_SLOTS + 1);
  localparam int RUN_W   = $clog2(MAX_RUN + 2);

  localparam logic [LINK_W-1:0] NO_LINK = '1;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;

  // request codes
  localparam logic REQ_ALLOC  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic              used;
    logic [LINK_W-1:0] link;
  } sec_entry_t;

  typedef struct packed {
    logic [7:0]        name;
    logic [SEC_AW-1:0] first;
    logic [5:0]        len;
  } tab_entry_t;

endpackage

### hdl/linked_block_allocator_top.sv
// Linked block allocator: sector map memory plus file table memory.
// Allocate: scan of the sector memory (one read port, one sector a cycle) for free sectors,
//   linking each claimed sector to the last; a short run releases the claimed sectors again.
// Lookup: search of the table entries (one a cycle), then one chain sector a cycle unless out stalls.
// Reset (rst_n, synchronous, active low) starts a clearing pass over the
//   sector memory; no item is accepted until it ends.
// Depends on lba_pkg.
module linked_block_allocator_top
  import lba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_file_name,
  input  logic [10:0] in_start_block,
  input  logic [5:0]  in_block_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_block_index,
  output logic        out_block_valid,
  output logic        out_last
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_CHK  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_A_FIN  = 4'd4;
  localparam logic [3:0] S_REL_RD = 4'd5;
  localparam logic [3:0] S_REL_WR = 4'd6;
  localparam logic [3:0] S_L_SRCH = 4'd7;
  localparam logic [3:0] S_L_WALK = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  // memories
  sec_entry_t sec_mem [0:SECTOR_COUNT-1];
  tab_entry_t tab_mem [0:FILE_SLOTS-1];

  sec_entry_t        sec_rd_r;
  logic              sec_re;
  logic [SEC_AW-1:0] sec_raddr;
  logic              sec_we;
  logic [SEC_AW-1:0] sec_waddr;
  sec_entry_t        sec_wdata;

  tab_entry_t        tab_rd_r;
  logic              tab_re;
  logic [TAB_AW-1:0] tab_raddr;
  logic              tab_we;
  tab_entry_t        tab_wdata;

  // control and request registers
  logic [3:0]        state_r, state_nxt;
  logic [SEC_AW-1:0] clr_r, clr_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              req_type_r;
  logic [7:0]        name_r;
  logic [10:0]       start_r;
  logic [5:0]        count_r, count_nxt;
  logic [SEC_AW:0]   scan_r, scan_nxt;
  logic [SEC_AW-1:0] pend_j_r, pend_j_nxt;
  logic              pend_r, pend_nxt;
  logic [SEC_AW-1:0] prev_r, prev_nxt;
  logic              prev_v_r, prev_v_nxt;
  logic [RUN_W-1:0]  got_r, got_nxt;
  logic [SEC_AW-1:0] walk_r, walk_nxt;
  logic [TOT_W-1:0]  ent_r, ent_nxt;

  // pending single result
  logic [2:0]        res_status_r, res_status_nxt;
  logic [9:0]        res_idx_r, res_idx_nxt;
  logic              res_bv_r, res_bv_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [9:0]        out_idx_r, out_idx_nxt;
  logic              out_bv_r, out_bv_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc;
  logic              out_free;
  logic              free_hit;
  logic              issue;
  logic [RUN_W-1:0]  got_sum;
  logic              walk_last;
  logic              tab_hit;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_index = out_idx_r;
  assign out_block_valid = out_bv_r;
  assign out_last        = out_last_r;

  // scan and walk helpers
  assign free_hit  = pend_r & ~sec_rd_r.used;
  assign got_sum   = got_r + RUN_W'(free_hit);
  assign issue     = (int'(scan_r) < SECTOR_COUNT);
  assign walk_last = (got_r + RUN_W'(1) == RUN_W'(count_r)) ||
                     (int'(sec_rd_r.link) >= SECTOR_COUNT);
  assign tab_hit   = pend_r & (tab_rd_r.name == name_r);

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    total_nxt      = total_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    pend_j_nxt     = pend_j_r;
    prev_nxt       = prev_r;
    prev_v_nxt     = prev_v_r;
    got_nxt        = got_r;
    walk_nxt       = walk_r;
    ent_nxt        = ent_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_bv_nxt     = res_bv_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_bv_nxt     = out_bv_r;
    out_last_nxt   = out_last_r;
    sec_re         = 1'b0;
    sec_raddr      = '0;
    sec_we         = 1'b0;
    sec_waddr      = '0;
    sec_wdata      = '{used: 1'b0, link: NO_LINK};
    tab_re         = 1'b0;
    tab_raddr      = '0;
    tab_we         = 1'b0;
    tab_wdata      = '{name: name_r, first: SEC_AW'(start_r), len: count_r};

    case (state_r)
      S_CLR: begin
        // sweep the sector map to free, no link
        sec_we    = 1'b1;
        sec_waddr = clr_r;
        clr_nxt   = clr_r + SEC_AW'(1);
        if (int'(clr_r) == SECTOR_COUNT - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_idx_nxt = '0;
        res_bv_nxt  = 1'b0;
        count_nxt   = in_block_count;
        if (in_acc) begin
          if (in_req_type == REQ_ALLOC) begin
            if (int'(total_r) >= FILE_SLOTS) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_RESP;
            end else if (int'(in_start_block) >= SECTOR_COUNT) begin
              res_status_nxt = ST_BAD_START;
              state_nxt      = S_RESP;
            end else begin
              sec_re    = 1'b1;
              sec_raddr = SEC_AW'(in_start_block);
              state_nxt = S_A_CHK;
            end
          end else begin
            ent_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_L_SRCH;
          end
        end
      end
      S_A_CHK: begin
        if (sec_rd_r.used) begin
          res_status_nxt = ST_BAD_START;
          state_nxt      = S_RESP;
        end else if (int'(count_r) > MAX_RUN) begin
          res_status_nxt = ST_SHORT;
          state_nxt      = S_RESP;
        end else if (count_r == '0) begin
          // empty file: record with first sector 0
          tab_we          = 1'b1;
          tab_wdata.first = '0;
          total_nxt       = total_r + TOT_W'(1);
          res_status_nxt  = ST_OK;
          state_nxt       = S_RESP;
        end else begin
          scan_nxt   = (SEC_AW + 1)'(start_r);
          pend_nxt   = 1'b0;
          prev_v_nxt = 1'b0;
          got_nxt    = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // link the previous claimed sector to the one just found free
        if (free_hit) begin
          if (prev_v_r) begin
            sec_we    = 1'b1;
            sec_waddr = prev_r;
            sec_wdata = '{used: 1'b1, link: LINK_W'(pend_j_r)};
          end
          prev_nxt   = pend_j_r;
          prev_v_nxt = 1'b1;
        end
        got_nxt = got_sum;
        if (got_sum == RUN_W'(count_r)) begin
          state_nxt = S_A_FIN;
        end else if (!pend_r && !issue) begin
          res_status_nxt = ST_SHORT;
          walk_nxt       = SEC_AW'(start_r);
          state_nxt      = (got_r != '0) ? S_REL_RD : S_RESP;
        end else begin
          pend_nxt   = issue;
          pend_j_nxt = SEC_AW'(scan_r);
          if (issue) begin
            sec_re    = 1'b1;
            sec_raddr = SEC_AW'(scan_r);
            scan_nxt  = scan_r + (SEC_AW + 1)'(1);
          end
        end
      end
      S_A_FIN: begin
        // close the chain and record the file
        sec_we         = 1'b1;
        sec_waddr      = prev_r;
        sec_wdata      = '{used: 1'b1, link: NO_LINK};
        tab_we         = 1'b1;
        total_nxt      = total_r + TOT_W'(1);
        res_status_nxt = ST_OK;
        res_idx_nxt    = 10'(start_r);
        res_bv_nxt     = 1'b1;
        state_nxt      = S_RESP;
      end
      S_REL_RD: begin
        sec_re    = 1'b1;
        sec_raddr = walk_r;
        state_nxt = S_REL_WR;
      end
      S_REL_WR: begin
        // free this sector, follow its link
        sec_we    = 1'b1;
        sec_waddr = walk_r;
        if (int'(sec_rd_r.link) >= SECTOR_COUNT) begin
          state_nxt = S_RESP;
        end else begin
          walk_nxt  = SEC_AW'(sec_rd_r.link);
          state_nxt = S_REL_RD;
        end
      end
      S_L_SRCH: begin
        if (tab_hit) begin
          walk_nxt  = tab_rd_r.first;
          count_nxt = tab_rd_r.len;
          got_nxt   = '0;
          if (tab_rd_r.len == '0) begin
            res_status_nxt = ST_FOUND;
            state_nxt      = S_RESP;
          end else begin
            sec_re    = 1'b1;
            sec_raddr = tab_rd_r.first;
            state_nxt = S_L_WALK;
          end
        end else if (!pend_r && (ent_r >= total_r)) begin
          res_status_nxt = ST_MISSING;
          state_nxt      = S_RESP;
        end else begin
          pend_nxt = (ent_r < total_r);
          if (ent_r < total_r) begin
            tab_re    = 1'b1;
            tab_raddr = TAB_AW'(ent_r);
            ent_nxt   = ent_r + TOT_W'(1);
          end
        end
      end
      S_L_WALK: begin
        // emit one chain sector per result
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FOUND;
          out_idx_nxt    = 10'(walk_r);
          out_bv_nxt     = 1'b1;
          out_last_nxt   = walk_last;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            got_nxt   = got_r + RUN_W'(1);
            walk_nxt  = SEC_AW'(sec_rd_r.link);
            sec_re    = 1'b1;
            sec_raddr = SEC_AW'(sec_rd_r.link);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_bv_nxt     = res_bv_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r <= in_req_type;
      name_r     <= in_file_name;
      start_r    <= in_start_block;
    end
    count_r      <= count_nxt;
    scan_r       <= scan_nxt;
    pend_j_r     <= pend_j_nxt;
    prev_r       <= prev_nxt;
    prev_v_r     <= prev_v_nxt;
    got_r        <= got_nxt;
    walk_r       <= walk_nxt;
    ent_r        <= ent_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_bv_r     <= res_bv_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_bv_r     <= out_bv_nxt;
    out_last_r   <= out_last_nxt;
  end

  // sector map memory
  always_ff @(posedge clk) begin
    if (sec_we) begin
      sec_mem[sec_waddr] <= sec_wdata;
    end
    if (sec_re) begin
      sec_rd_r <= sec_mem[sec_raddr];
    end
  end

  // file table memory
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[TAB_AW'(total_r)] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rd_r <= tab_mem[tab_raddr];
    end
  end

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total_r) <= FILE_SLOTS)
    else $error("file table count exceeds slots");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!sec_we && !tab_we))
    else $error("memory write while idle");

  a_lookup_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L_WALK) |-> (req_type_r == REQ_LOOKUP))
    else $error("chain walk outside a lookup");

endmodule
